### design/slxfr_pkg.sv
// ----------------------------------------------------------------------------
// slxfr_pkg
// Shared constants and types of the sync/length/XOR frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package slxfr_pkg;

  localparam int MAX_FRAME_LEN = 64;

  localparam logic [7:0] SYNC_FIRST  = 8'hBE;
  localparam logic [7:0] SYNC_SECOND = 8'hEF;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_HANDSHAKE_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VESSEL_LEN    = 1'b1;

  localparam logic [CFG_DATA_W-1:0] HANDSHAKE_LEN_RESET = 7'd4;
  localparam logic [CFG_DATA_W-1:0] VESSEL_LEN_RESET    = 7'd64;

  typedef enum logic [1:0] {
    ST_FRAME    = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_LENGTH   = 2'd2,
    ST_KIND     = 2'd3
  } status_t;

  typedef struct packed {
    logic    ld_len;
    logic    ld_kind;
    logic    store;
    logic    out_kind;
    logic    out_status;
    status_t status_code;
    logic    status_kind;
    logic    rd_issue;
    logic    out_pay;
  } cmd_t;

  typedef struct packed {
    logic is_sync1;
    logic is_sync2;
    logic kind_bad;
    logic len_bad;
    logic body_more;
    logic check_ok;
    logic cnt_zero;
    logic pay_last;
    logic out_free;
    logic rx_kind;
    logic frame_kind;
  } stat_t;

endpackage

`default_nettype wire

### design/slxfr_ram.sv
// ----------------------------------------------------------------------------
// slxfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module slxfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/slxfr_dp.sv
// ----------------------------------------------------------------------------
// slxfr_dp
// Datapath: frame length and kind registers, running XOR, payload store and
// the output beat register.
// ----------------------------------------------------------------------------
`default_nettype none

module slxfr_dp #(
  parameter int MAX_FRAME_LEN = slxfr_pkg::MAX_FRAME_LEN
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [slxfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [slxfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [7:0]                         rx_byte,
  input  wire slxfr_pkg::cmd_t                    cmd,
  output slxfr_pkg::stat_t                        stat,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [7:0]                              out_byte,
  output logic [1:0]                              out_status,
  output logic                                    out_kind,
  output logic                                    out_last
);

  localparam int LEN_W = $clog2(MAX_FRAME_LEN + 1);
  localparam int CNT_W = $clog2(MAX_FRAME_LEN);

  logic [slxfr_pkg::CFG_DATA_W-1:0] handshake_len;
  logic [slxfr_pkg::CFG_DATA_W-1:0] vessel_len;
  logic [LEN_W-1:0]                 expected_len;
  logic [CNT_W-1:0]                 byte_count;
  logic [CNT_W-1:0]                 rd_idx;
  logic [7:0]                       running_check;
  logic                             kind_reg;
  logic [7:0]                       ram_rdata;
  logic [slxfr_pkg::CFG_DATA_W-1:0] want_len;
  logic                             len_in_range;

  slxfr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME_LEN)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (byte_count),
    .wdata (rx_byte),
    .re    (cmd.rd_issue),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  assign want_len     = rx_byte[0] ? vessel_len : handshake_len;
  assign len_in_range = (rx_byte != 8'd0) && ({1'b0, rx_byte} <= 9'(MAX_FRAME_LEN));

  assign stat.is_sync1   = (rx_byte == slxfr_pkg::SYNC_FIRST);
  assign stat.is_sync2   = (rx_byte == slxfr_pkg::SYNC_SECOND);
  assign stat.kind_bad   = (rx_byte > 8'd1);
  assign stat.len_bad    = (expected_len == '0) || (8'(expected_len) != {1'b0, want_len});
  assign stat.body_more  = (9'(byte_count) + 9'd1) < 9'(expected_len);
  assign stat.check_ok   = (rx_byte == running_check);
  assign stat.cnt_zero   = (byte_count == '0);
  assign stat.pay_last   = ({1'b0, rd_idx} + (CNT_W + 1)'(1)) == {1'b0, byte_count};
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.rx_kind    = rx_byte[0];
  assign stat.frame_kind = kind_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      handshake_len <= slxfr_pkg::HANDSHAKE_LEN_RESET;
      vessel_len    <= slxfr_pkg::VESSEL_LEN_RESET;
      expected_len  <= '0;
      byte_count    <= '0;
      rd_idx        <= '0;
      running_check <= '0;
      kind_reg      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          slxfr_pkg::REG_HANDSHAKE_LEN: handshake_len <= cfg_data;
          slxfr_pkg::REG_VESSEL_LEN:    vessel_len    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.ld_len) begin
        expected_len  <= len_in_range ? LEN_W'(rx_byte) : '0;
        running_check <= rx_byte;
      end
      if (cmd.ld_kind) begin
        kind_reg      <= rx_byte[0];
        running_check <= running_check ^ rx_byte;
        byte_count    <= '0;
      end
      if (cmd.store) begin
        byte_count    <= byte_count + CNT_W'(1);
        running_check <= running_check ^ rx_byte;
      end
      if (cmd.out_kind) begin
        rd_idx <= '0;
      end
      if (cmd.out_pay) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (cmd.out_kind || cmd.out_status || cmd.out_pay) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_status) begin
      out_byte   <= 8'd0;
      out_status <= cmd.status_code;
      out_kind   <= cmd.status_kind;
      out_last   <= 1'b1;
    end else if (cmd.out_kind) begin
      out_byte   <= {7'd0, kind_reg};
      out_status <= slxfr_pkg::ST_FRAME;
      out_kind   <= kind_reg;
      out_last   <= (byte_count == '0);
    end else if (cmd.out_pay) begin
      out_byte   <= ram_rdata;
      out_status <= slxfr_pkg::ST_FRAME;
      out_kind   <= kind_reg;
      out_last   <= stat.pay_last;
    end
  end

endmodule

`default_nettype wire

### design/slxfr_ctrl.sv
// ----------------------------------------------------------------------------
// slxfr_ctrl
// Controller: sync hunt, header checks, payload collection and run emission.
// ----------------------------------------------------------------------------
`default_nettype none

module slxfr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire slxfr_pkg::stat_t stat,
  output slxfr_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    HUNT1,
    HUNT2,
    LEN,
    KIND,
    BODY,
    RD,
    PUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   acc;

  assign in_ready = (state inside {HUNT1, HUNT2, LEN, KIND, BODY}) && stat.out_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      HUNT1: begin
        if (acc && stat.is_sync1) begin
          state_next = HUNT2;
        end
      end
      HUNT2: begin
        if (acc) begin
          state_next = stat.is_sync2 ? LEN : HUNT1;
        end
      end
      LEN: begin
        if (acc) begin
          cmd.ld_len = 1'b1;
          state_next = KIND;
        end
      end
      KIND: begin
        if (acc) begin
          if (stat.kind_bad) begin
            cmd.out_status  = 1'b1;
            cmd.status_code = slxfr_pkg::ST_KIND;
            cmd.status_kind = 1'b0;
            state_next      = HUNT1;
          end else if (stat.len_bad) begin
            cmd.out_status  = 1'b1;
            cmd.status_code = slxfr_pkg::ST_LENGTH;
            cmd.status_kind = stat.rx_kind;
            state_next      = HUNT1;
          end else begin
            cmd.ld_kind = 1'b1;
            state_next  = BODY;
          end
        end
      end
      BODY: begin
        if (acc) begin
          if (stat.body_more) begin
            cmd.store = 1'b1;
          end else if (stat.check_ok) begin
            cmd.out_kind = 1'b1;
            state_next   = stat.cnt_zero ? HUNT1 : RD;
          end else begin
            cmd.out_status  = 1'b1;
            cmd.status_code = slxfr_pkg::ST_CHECKSUM;
            cmd.status_kind = stat.frame_kind;
            state_next      = HUNT1;
          end
        end
      end
      RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = PUT;
      end
      PUT: begin
        if (stat.out_free) begin
          cmd.out_pay = 1'b1;
          state_next  = stat.pay_last ? HUNT1 : RD;
        end
      end
      default: state_next = HUNT1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HUNT1;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### design/sync_length_xor_frame_receiver.sv
// Latency: a status beat or the kind beat of a good frame is offered the cycle after
// the beat that decides it; each payload beat is then read from the single payload store
// in state RD by a registered read and offered from state PUT before the next read.
// Throughput: one received byte per cycle while the output can take a beat; input is held off while a run is emitted.
// Reset: synchronous, active high; returns to sync hunt and restores the lengths 4 and 64.
// ----------------------------------------------------------------------------
// sync_length_xor_frame_receiver
// Sync-word framed receiver with length check and XOR checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_xor_frame_receiver #(
  parameter int MAX_FRAME_LEN = slxfr_pkg::MAX_FRAME_LEN
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [slxfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [slxfr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [7:0]                       s_axis_tdata,  // [7:0] rx_byte
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [7:0]                            m_axis_tdata,  // [7:0] out_byte
  output logic [2:0]                            m_axis_tuser,  // [1:0] status, [2] frame_kind
  output logic                                  m_axis_tlast
);

  slxfr_pkg::cmd_t  cmd;
  slxfr_pkg::stat_t stat;
  logic [1:0]       out_status;
  logic             out_kind;

  slxfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slxfr_dp #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx_byte    (s_axis_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_status (out_status),
    .out_kind   (out_kind),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tuser = {out_kind, out_status};

  a_ready_needs_room: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input taken while output beat is stalled");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1:0] != slxfr_pkg::ST_FRAME) |->
      (m_axis_tlast && m_axis_tdata == 8'd0))
    else $error("status beat not single or carries data");

  a_kind_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1:0] == slxfr_pkg::ST_KIND) |-> !m_axis_tuser[2])
    else $error("unknown kind status with nonzero frame kind");

endmodule

`default_nettype wire

### tb/tb_sync_length_xor_frame_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_length_xor_frame_receiver
// Drives received bytes into the sync/length/XOR frame receiver. A local
// frame decoder predicts every output beat, and each output beat is checked
// against the oldest prediction. Both sides idle at random, and the output is
// also held off for a long stretch. The frame length registers are rewritten
// between phases, including their extremes.
// ----------------------------------------------------------------------------

module tb_sync_length_xor_frame_receiver;

  localparam int STALL_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    TAKE_LEN,
    TAKE_KIND,
    TAKE_BODY
  } rx_phase_t;

  typedef struct packed {
    logic [7:0]         data;
    slxfr_pkg::status_t status;
    logic               kind;
    logic               last;
  } frame_beat_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [slxfr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [slxfr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [7:0]                       s_axis_tdata = 8'h00;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [7:0]                       m_axis_tdata;
  logic [2:0]                       m_axis_tuser;
  logic                             m_axis_tlast;

  // Decoder state and length registers as the block should hold them.
  logic [6:0]  hs_len = slxfr_pkg::HANDSHAKE_LEN_RESET;
  logic [6:0]  vs_len = slxfr_pkg::VESSEL_LEN_RESET;
  rx_phase_t   rx_phase = HUNT_FIRST;
  logic [6:0]  want_len = '0;
  logic [6:0]  body_count = '0;
  logic [7:0]  check_acc = '0;
  logic        cur_kind = 1'b0;
  logic [7:0]  payload [slxfr_pkg::MAX_FRAME_LEN];

  frame_beat_t expected_beats [$];
  logic [7:0]  body_bytes [$];
  int          err_count = 0;
  int          bytes_sent = 0;
  int          stall_cycles = 0;
  int          hold_req = 0;
  int          hold_left = 0;
  bit          idle_on = 1'b1;

  sync_length_xor_frame_receiver dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
    .m_axis_tuser  (m_axis_tuser),   // [1:0] status, [2] frame_kind
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endfunction

  function automatic void push_status(input slxfr_pkg::status_t code, input logic kind);
    expected_beats.push_back('{data: 8'h00, status: code, kind: kind, last: 1'b1});
    rx_phase = HUNT_FIRST;
  endfunction

  function automatic void decode_rx_byte(input logic [7:0] b);
    logic [6:0] reg_len;
    case (rx_phase)
      HUNT_FIRST: begin
        if (b == slxfr_pkg::SYNC_FIRST) rx_phase = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        rx_phase = (b == slxfr_pkg::SYNC_SECOND) ? TAKE_LEN : HUNT_FIRST;
      end
      TAKE_LEN: begin
        want_len = (b >= 1 && b <= slxfr_pkg::MAX_FRAME_LEN) ? b[6:0] : 7'd0;
        check_acc = b;
        rx_phase = TAKE_KIND;
      end
      TAKE_KIND: begin
        if (b > 8'd1) begin
          push_status(slxfr_pkg::ST_KIND, 1'b0);
        end else begin
          cur_kind = b[0];
          reg_len = cur_kind ? vs_len : hs_len;
          if (want_len == 7'd0 || want_len != reg_len) begin
            push_status(slxfr_pkg::ST_LENGTH, cur_kind);
          end else begin
            check_acc ^= b;
            body_count = '0;
            rx_phase = TAKE_BODY;
          end
        end
      end
      TAKE_BODY: begin
        if (body_count + 1 < want_len) begin
          payload[body_count] = b;
          body_count++;
          check_acc ^= b;
        end else if (b != check_acc) begin
          push_status(slxfr_pkg::ST_CHECKSUM, cur_kind);
        end else begin
          expected_beats.push_back('{data: {7'd0, cur_kind}, status: slxfr_pkg::ST_FRAME,
                                     kind: cur_kind, last: body_count == 0});
          for (int i = 0; i < body_count; i++) begin
            expected_beats.push_back('{data: payload[i], status: slxfr_pkg::ST_FRAME,
                                       kind: cur_kind, last: i + 1 == body_count});
          end
          rx_phase = HUNT_FIRST;
        end
      end
      default: rx_phase = HUNT_FIRST;
    endcase
  endfunction

  // Output side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_req != 0) begin
      hold_left = hold_req - 1;
      hold_req = 0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(idle_on && $urandom_range(99) < 8);
    end
  end

  always @(posedge clk) begin
    frame_beat_t got;
    frame_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{data: m_axis_tdata, status: slxfr_pkg::status_t'(m_axis_tuser[1:0]),
              kind: m_axis_tuser[2], last: m_axis_tlast};
      if (expected_beats.size() == 0) begin
        note_error($sformatf("unexpected beat data=%h status=%0d kind=%0b last=%0b",
                             got.data, got.status, got.kind, got.last));
      end else begin
        want = expected_beats.pop_front();
        if (got.data !== want.data || got.status !== want.status ||
            got.kind !== want.kind || got.last !== want.last) begin
          note_error($sformatf({"beat mismatch: expected data=%h status=%0d kind=%0b ",
                                "last=%0b, actual data=%h status=%0d kind=%0b last=%0b"},
                               want.data, want.status, want.kind, want.last,
                               got.data, got.status, got.kind, got.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_sync_length_xor_frame_receiver: done, errors");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decode_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic fill_body(input int n);
    logic [7:0] b;
    body_bytes.delete();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(15))
        0:       b = slxfr_pkg::SYNC_FIRST;
        1:       b = slxfr_pkg::SYNC_SECOND;
        default: b = $urandom_range(255);
      endcase
      body_bytes.push_back(b);
    end
  endtask

  // Sync pair, length, kind, the prepared body and an optional checksum.
  task automatic send_frame(input logic [7:0] len_byte, input logic [7:0] kind_byte,
                            input bit with_sum, input bit bad_sum);
    logic [7:0] sum;
    sum = len_byte ^ kind_byte;
    send_byte(slxfr_pkg::SYNC_FIRST);
    send_byte(slxfr_pkg::SYNC_SECOND);
    send_byte(len_byte);
    send_byte(kind_byte);
    foreach (body_bytes[i]) begin
      sum ^= body_bytes[i];
      send_byte(body_bytes[i]);
    end
    if (with_sum) begin
      send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    end
  endtask

  task automatic send_good_frame(input logic kind);
    logic [6:0] len;
    len = kind ? vs_len : hs_len;
    fill_body(int'(len) - 1);
    send_frame({1'b0, len}, {7'd0, kind}, 1'b1, 1'b0);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_lengths(input logic [6:0] hs, input logic [6:0] vs);
    cfg_we    <= 1'b1;
    cfg_index <= slxfr_pkg::REG_HANDSHAKE_LEN;
    cfg_data  <= hs;
    @(posedge clk);
    hs_len = hs;
    cfg_index <= slxfr_pkg::REG_VESSEL_LEN;
    cfg_data  <= vs;
    @(posedge clk);
    vs_len = vs;
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_cases();
    body_bytes = '{slxfr_pkg::SYNC_FIRST, slxfr_pkg::SYNC_SECOND, 8'hFF};
    send_frame(8'd4, 8'd0, 1'b1, 1'b0);
    fill_body(3);
    send_frame(8'd4, 8'd0, 1'b1, 1'b1);
    body_bytes.delete();
    send_frame(8'd4, 8'd2, 1'b0, 1'b0);
    send_frame(8'h80, 8'd1, 1'b0, 1'b0);
    send_byte(slxfr_pkg::SYNC_FIRST);
    send_byte(8'h00);
    wait_idle();
  endtask

  task automatic test_length_registers();
    write_lengths(7'd1, 7'd64);
    send_good_frame(1'b0);
    send_good_frame(1'b1);
    body_bytes.delete();
    send_frame(8'd0, 8'd0, 1'b0, 1'b0);
    send_frame(8'd1, 8'd1, 1'b0, 1'b0);
    send_frame(8'd1, 8'hFF, 1'b0, 1'b0);
    wait_idle();

    write_lengths(7'd64, 7'd1);
    send_good_frame(1'b0);
    send_good_frame(1'b1);
    body_bytes.delete();
    send_frame(8'd1, 8'd1, 1'b1, 1'b1);
    wait_idle();

    write_lengths(7'd0, 7'd127);
    body_bytes.delete();
    send_frame(8'd0, 8'd0, 1'b0, 1'b0);
    send_frame(8'd127, 8'd1, 1'b0, 1'b0);
    wait_idle();

    write_lengths(slxfr_pkg::HANDSHAKE_LEN_RESET, slxfr_pkg::VESSEL_LEN_RESET);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_req = 300;
    send_good_frame(1'b1);
    send_good_frame(1'b0);
    send_good_frame(1'b0);
    send_good_frame(1'b1);
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int goal;
    int frame_no;
    int pick;
    logic [7:0] len_byte;
    logic [6:0] hs;
    logic [6:0] vs;
    goal = 430;
    frame_no = 0;
    while (bytes_sent < goal) begin
      if (frame_no % 8 == 0) begin
        wait_idle();
        hs = ($urandom_range(9) == 0) ? 7'd64 : 7'($urandom_range(1, 12));
        vs = ($urandom_range(9) == 0) ? 7'd64 : 7'($urandom_range(1, 12));
        write_lengths(hs, vs);
      end
      idle_on = !(frame_no >= 15 && frame_no < 35);
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_good_frame(1'($urandom_range(1)));
      end else if (pick < 78) begin
        fill_body(int'(hs_len) - 1);
        send_frame({1'b0, hs_len}, 8'd0, 1'b1, 1'b1);
      end else if (pick < 85) begin
        do len_byte = $urandom_range(255); while (len_byte == {1'b0, vs_len});
        body_bytes.delete();
        send_frame(len_byte, 8'd1, 1'b0, 1'b0);
      end else if (pick < 90) begin
        body_bytes.delete();
        send_frame(8'($urandom_range(255)), 8'($urandom_range(2, 255)), 1'b0, 1'b0);
      end else begin
        if ($urandom_range(2) == 0) send_byte(slxfr_pkg::SYNC_FIRST);
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end
      frame_no++;
    end
    idle_on = 1'b1;
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_length_registers();
    test_backpressure();
    test_random_frames();
    repeat (20) @(posedge clk);
    if (expected_beats.size() != 0) begin
      note_error($sformatf("%0d expected beats never arrived", expected_beats.size()));
    end
    if (err_count == 0) begin
      $display("tb_sync_length_xor_frame_receiver: done, clean");
    end else begin
      $display("tb_sync_length_xor_frame_receiver: done, errors");
    end
    $finish;
  end

endmodule

### sync_length_xor_frame_receiver.f
design/slxfr_pkg.sv
design/slxfr_ram.sv
design/slxfr_dp.sv
design/slxfr_ctrl.sv
design/sync_length_xor_frame_receiver.sv
tb/tb_sync_length_xor_frame_receiver.sv
